// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define LSD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("lsd: invariant violated");

// Antecedent implies consequent in the same cycle.
`define LSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsd: same-cycle implication violated");

// Antecedent implies consequent in the next cycle.
`define LSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsd: next-cycle implication violated");

`endif

// ----- hdl/lsd_pkg.sv -----
package lsd_pkg;

	// Fixed field widths
	localparam int CAP_W   = 7;
	localparam int DEPTH_W = 6;

	// Capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;  // take item, compare against stack
		logic commit;   // shift stack, update occupancy, emit result
	} lsd_cmd_t;

endpackage

// ----- hdl/lsd_ctrl.sv -----
module lsd_ctrl import lsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output lsd_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands and handshake
	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.commit  = (state_q == ST_UPDATE);

endmodule

// ----- hdl/lsd_datapath.sv -----
`include "assert_macros.svh"

module lsd_datapath import lsd_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int PAGE_BITS   = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsd_cmd_t             cmd,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic                 cfg_we,
	input  logic [CAP_W-1:0]     capacity,
	output logic                 done,
	output logic                 hit,
	output logic [DEPTH_W-1:0]   stack_depth
);

	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int OCC_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [PAGE_BITS-1:0] stack_q [STACK_DEPTH];
	logic [OCC_W-1:0]     occ_q;
	logic [CAP_W-1:0]     capacity_q;

	logic [STACK_DEPTH-1:0] match;
	logic [IDX_W-1:0]       match_idx;
	logic                   match_any;

	logic [PAGE_BITS-1:0] page_s1;
	logic                 hit_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic [IDX_W-1:0] pos;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] occ_inc;
	logic [OCC_W-1:0] occ_next;

	logic                 done_q;
	logic                 hit_q;
	logic [DEPTH_W-1:0]   depth_q;

	// Compare every resident entry against the incoming page
	always_comb begin
		match = '0;
		for (int d = 0; d < STACK_DEPTH; d++) begin
			match[d] = (OCC_W'(d) < occ_q) && (stack_q[d] == page_number);
		end
	end

	// Resident pages are distinct, so the match vector is one-hot or empty
	always_comb begin
		match_idx = '0;
		for (int d = 0; d < STACK_DEPTH; d++) begin
			if (match[d]) match_idx = match_idx | IDX_W'(d);
		end
	end

	assign match_any = |match;

	// Compare stage register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_s1 <= page_number;
			hit_s1  <= match_any;
			idx_s1  <= match_idx;
		end
	end

	// Deepest entry that moves: hit position, or on a miss the fill level, capped at the last entry
	always_comb begin
		if (hit_s1) begin
			pos = idx_s1;
		end else if (occ_q >= OCC_W'(STACK_DEPTH)) begin
			pos = IDX_W'(STACK_DEPTH - 1);
		end else begin
			pos = occ_q[IDX_W-1:0];
		end
	end

	// Recency stack: shift down to pos, new page on top
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stack_q[0] <= page_s1;
			for (int k = 1; k < STACK_DEPTH; k++) begin
				if (IDX_W'(k) <= pos) stack_q[k] <= stack_q[k-1];
			end
		end
	end

	// Effective capacity: zero reads as one, clamp to stack size
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(STACK_DEPTH)) begin
			cap_eff = CMP_W'(STACK_DEPTH);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// Occupancy after a miss: grow if room, then truncate to capacity
	always_comb begin
		if (occ_q < OCC_W'(STACK_DEPTH)) begin
			occ_inc = CMP_W'(occ_q) + CMP_W'(1);
		end else begin
			occ_inc = CMP_W'(occ_q);
		end
		occ_next = OCC_W'((occ_inc > cap_eff) ? cap_eff : occ_inc);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			capacity_q <= CAP_RESET;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) capacity_q <= capacity;
			if (cmd.commit && !hit_s1) occ_q <= occ_next;
			done_q <= cmd.commit;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q   <= hit_s1;
			depth_q <= hit_s1 ? DEPTH_W'(idx_s1) : '0;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign stack_depth = depth_q;

	// Checks
	`LSD_ASSERT_ALWAYS(a_match_unique, clk, arst_n, $onehot0(match))
	`LSD_ASSERT_ALWAYS(a_occ_bound, clk, arst_n, occ_q <= OCC_W'(STACK_DEPTH))
	`LSD_ASSERT_IMPL(a_hit_below_occ, clk, arst_n, cmd.capture && match_any, OCC_W'(match_idx) < occ_q)
	`LSD_ASSERT_NEXT(a_miss_grows, clk, arst_n, cmd.commit && !hit_s1 && (CMP_W'(occ_q) < cap_eff), CMP_W'(occ_q) == CMP_W'($past(occ_q)) + CMP_W'(1))

endmodule

// ----- hdl/lru_stack_distance_unit.sv -----
// Channel   Direction  Handshake              Ports
// config    in         cfg_we                 capacity
// item      in         start && !busy         page_number
// result    out        done (one-cycle pulse) hit, stack_depth
//
// In the accept cycle the page is compared against all resident entries in
// parallel; the next cycle shifts the recency stack. busy holds off a new
// item while the stack shifts; done pulses in the cycle after the shift.
// Reset clears occupancy and sets capacity to 64; no clearing pass.
// The receiver cannot stall; each result is valid only while done is high.
module lru_stack_distance_unit import lsd_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int PAGE_BITS   = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_W-1:0]     capacity,
	input  logic                 start,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 busy,
	output logic                 done,
	output logic                 hit,
	output logic [DEPTH_W-1:0]   stack_depth
);

	lsd_cmd_t cmd;

	// Sequencer
	lsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Stack, compare and occupancy
	lsd_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.PAGE_BITS   (PAGE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.page_number (page_number),
		.cfg_we      (cfg_we),
		.capacity    (capacity),
		.done        (done),
		.hit         (hit),
		.stack_depth (stack_depth)
	);

endmodule

// ----- verif/tb_lru_stack_distance_unit.sv -----
module tb_lru_stack_distance_unit;
	import lsd_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int PAGE_BITS   = 20;
	localparam int WDOG_LIMIT  = 500;

	typedef logic [PAGE_BITS-1:0] page_t;

	typedef struct packed {
		logic               hit;
		logic [DEPTH_W-1:0] depth;
	} distance_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CAP_W-1:0]   capacity = CAP_RESET;
	logic               start = 1'b0;
	page_t              page_number = '0;
	logic               busy;
	logic               done;
	logic               hit;
	logic [DEPTH_W-1:0] stack_depth;

	// Predictor state: recency order, entry 0 is MRU
	page_t            lru_pages [STACK_DEPTH];
	int               resident_count = 0;
	logic [CAP_W-1:0] frame_limit = CAP_RESET;

	distance_t pending_distances[$];
	int        err_count = 0;
	int        sender_idle_pct = 0;
	int        quiet_cycles = 0;

	lru_stack_distance_unit #(
		.STACK_DEPTH(STACK_DEPTH),
		.PAGE_BITS  (PAGE_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.capacity   (capacity),
		.start      (start),
		.page_number(page_number),
		.busy       (busy),
		.done       (done),
		.hit        (hit),
		.stack_depth(stack_depth)
	);

	always #5 clk = ~clk;

	// Look the page up in the recency stack, move it to the top, return its distance
	function automatic distance_t touch_page(input page_t page);
		distance_t r;
		int        occ;
		int        cap;
		int        pos;
		occ = resident_count;
		cap = int'(frame_limit);
		if (cap < 1) cap = 1;
		if (cap > STACK_DEPTH) cap = STACK_DEPTH;
		if (occ > STACK_DEPTH) occ = STACK_DEPTH;
		pos = -1;
		for (int d = 0; d < occ; d++) begin
			if (pos < 0 && lru_pages[d] == page) pos = d;
		end
		r = '0;
		if (pos >= 0) begin
			r.hit = 1'b1;
			r.depth = pos[DEPTH_W-1:0];
		end else begin
			// miss: push on top, then trim to capacity
			pos = (occ < STACK_DEPTH) ? occ : STACK_DEPTH - 1;
			if (occ < STACK_DEPTH) occ++;
			if (occ > cap) occ = cap;
			resident_count = occ;
		end
		for (int k = pos; k > 0; k--) lru_pages[k] = lru_pages[k-1];
		lru_pages[0] = page;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Result checker: each done pulse is matched against the oldest expectation
	always @(posedge clk) begin
		distance_t exp_d;
		if (arst_n && done) begin
			if (pending_distances.size() == 0) begin
				report_mismatch($sformatf("unexpected result hit=%0b depth=%0d",
					hit, stack_depth));
			end else begin
				exp_d = pending_distances.pop_front();
				if (hit !== exp_d.hit)
					report_mismatch($sformatf("hit: exp %0b got %0b", exp_d.hit, hit));
				if (stack_depth !== exp_d.depth)
					report_mismatch($sformatf("stack_depth: exp %0d got %0d",
						exp_d.depth, stack_depth));
			end
		end
	end

	// Watchdog on cycles with no item accepted and no result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Send one item and record its expected distance once accepted
	task automatic send_page(input page_t page);
		start <= 1'b1;
		page_number <= page;
		do @(posedge clk); while (busy);
		pending_distances.push_back(touch_page(page));
	endtask

	task automatic maybe_idle();
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Hold off until every expected result is back and the block is idle
	task automatic drain_results();
		start <= 1'b0;
		while (pending_distances.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		capacity <= value;
		@(posedge clk);
		frame_limit = value;
		cfg_we <= 1'b0;
	endtask

	// Extreme page numbers, hits at MRU and one below
	task automatic test_extremes();
		send_page('0);
		send_page('1);
		send_page('0);
		send_page('0);
		send_page('1);
		send_page(20'h5A5A5);
	endtask

	// Small capacity: LRU page is evicted on overflow
	task automatic test_eviction();
		write_capacity(7'd2);
		send_page(20'h0000A);
		send_page(20'h0000B);
		send_page(20'h0000C);
		send_page(20'h0000A);
		send_page(20'h0000C);
	endtask

	// Zero capacity behaves as one frame
	task automatic test_capacity_zero();
		write_capacity(7'd0);
		send_page(20'h00055);
		send_page(20'h000AA);
		send_page(20'h00055);
		send_page(20'h00055);
	endtask

	// Oversized capacity saturates; lowering it keeps residents until the next miss
	task automatic test_capacity_lowered();
		write_capacity(7'd127);
		for (int i = 1; i <= 6; i++) send_page(page_t'(i));
		write_capacity(7'd2);
		send_page(20'h00001);
		send_page(20'h00077);
		send_page(20'h00003);
	endtask

	// Random references drawn mostly from a working set a bit larger than capacity
	task automatic run_segment(input logic [CAP_W-1:0] cap, input int n_items);
		page_t page_pool[];
		int    eff;
		int    pool_size;
		page_t page;
		write_capacity(cap);
		eff = int'(cap);
		if (eff < 1) eff = 1;
		if (eff > STACK_DEPTH) eff = STACK_DEPTH;
		pool_size = eff + $urandom_range(0, eff / 2 + 2);
		page_pool = new[pool_size];
		foreach (page_pool[i]) page_pool[i] = page_t'($urandom_range(0, 20'hFFFFF));
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 99) < 8) begin
				page = page_t'($urandom_range(0, 20'hFFFFF));
			end else begin
				page = page_pool[$urandom_range(0, pool_size - 1)];
			end
			send_page(page);
			if ($urandom_range(0, 59) == 0) begin
				drain_results();
			end else begin
				maybe_idle();
			end
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input logic [CAP_W-1:0] c0,
		input logic [CAP_W-1:0] c1, input logic [CAP_W-1:0] c2,
		input logic [CAP_W-1:0] c3);
		sender_idle_pct = idle_pct;
		run_segment(c0, 120);
		run_segment(c1, 120);
		run_segment(c2, 120);
		run_segment(c3, 120);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_eviction();
		test_capacity_zero();
		test_capacity_lowered();
		test_random_traffic(14, 7'd64, 7'd3, 7'd127, 7'd0);
		test_random_traffic(83, 7'd20, 7'd64, 7'd1, 7'd45);
		test_random_traffic(0, 7'd96, 7'd7, 7'd64, 7'd2);
		drain_results();
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
